@@ hdl/pal_pkg.sv @@
// shared types and constants for the positional array list unit
// no dependencies; imported by every other file of the block except pal_ram
package pal_pkg;

    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int PW     = 7;
    localparam int VW     = 32;
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [2:0] KIND_CLEAR   = 3'd0;
    localparam logic [2:0] KIND_APPEND  = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_DELETE  = 3'd3;
    localparam logic [2:0] KIND_SEARCH  = 3'd4;
    localparam logic [2:0] KIND_DISPLAY = 3'd5;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_MISS   = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        OP_CLEAR   = 7'b0000001,
        OP_APPEND  = 7'b0000010,
        OP_INSERT  = 7'b0000100,
        OP_DELETE  = 7'b0001000,
        OP_SEARCH  = 7'b0010000,
        OP_DISPLAY = 7'b0100000,
        OP_NOP     = 7'b1000000
    } t_op;

    typedef struct packed {
        logic [2:0]           kind;
        logic [PW-1:0]        position;
        logic signed [VW-1:0] value;
    } t_in;

    typedef struct packed {
        t_status              status;
        logic [PW-1:0]        found_position;
        logic signed [VW-1:0] entry_value;
        logic [PW-1:0]        entry_count;
        logic                 last;
    } t_out;

    typedef struct packed {
        t_op                  op;
        logic [PW-1:0]        position;
        logic signed [VW-1:0] value;
    } t_cmd;

endpackage

@@ hdl/positional_array_list_unit.sv @@
// a result passes the front register, the command queue and the result register before it leaves
// clear, append, no-op and rejected operations complete in the idle state once the result register is free
// insert shifts entries from the tail down to the position, delete shifts those after it up,
// search and display read entries in order; each is read on the ram read port before it is moved, compared or shown
// reset: count zero, queue and result register empty; ram contents are not cleared
// depends on pal_pkg, pal_front, pal_queue and pal_back
module positional_array_list_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pal_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pal_pkg::t_out o_out_data
);
    import pal_pkg::*;

    logic fr_valid;
    t_cmd fr_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic bk_pop;

    pal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd),
        .i_cmd_ready (q_ready)
    );

    pal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (q_ready),
        .i_cmd   (fr_cmd),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (bk_pop)
    );

    pal_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (bk_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hdl/pal_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/pal_front.sv @@
// front stage: takes input items and decodes the kind into a one-hot command
// depends on pal_pkg
module pal_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pal_pkg::t_in  i_in_data,
    output logic          o_cmd_valid,
    output pal_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import pal_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    t_op  n_op;
    logic accept;

    always_comb begin
        case (i_in_data.kind)
            KIND_CLEAR:   n_op = OP_CLEAR;
            KIND_APPEND:  n_op = OP_APPEND;
            KIND_INSERT:  n_op = OP_INSERT;
            KIND_DELETE:  n_op = OP_DELETE;
            KIND_SEARCH:  n_op = OP_SEARCH;
            KIND_DISPLAY: n_op = OP_DISPLAY;
            default:      n_op = OP_NOP;
        endcase
    end

    assign o_in_ready = !r_vld || i_cmd_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_cmd_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op       <= n_op;
            r_cmd.position <= i_in_data.position;
            r_cmd.value    <= i_in_data.value;
        end
    end

    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

endmodule

@@ hdl/pal_queue.sv @@
// short command queue between the front stage and the execution engine
// depends on pal_pkg
module pal_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pal_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output pal_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import pal_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_cnt;
    logic           push;
    logic           pop;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        logic [QAW-1:0] q;
        if (p == QAW'(QDEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + QAW'(1);
        end
        return q;
    endfunction

    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue fill count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with empty count");

endmodule

@@ hdl/pal_back.sv @@
// execution engine: runs list operations on the entry ram and drives results
// depends on pal_pkg and pal_ram
module pal_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pal_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pal_pkg::t_out o_out_data
);
    import pal_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_STEP = 9'b000000010,
        S_INS_MOVE = 9'b000000100,
        S_DEL_STEP = 9'b000001000,
        S_DEL_MOVE = 9'b000010000,
        S_DONE     = 9'b000100000,
        S_SRCH_RD  = 9'b001000000,
        S_SRCH_CMP = 9'b010000000,
        S_DISP_OUT = 9'b100000000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_idx, n_idx;
    logic           r_out_vld;
    t_out           r_out;
    t_out           res;
    logic           emit;
    logic           out_free;
    logic           full;
    logic           ins_bad;
    logic           del_bad;
    logic [PW-1:0]  cnt_w;
    logic [PW-1:0]  pos_m1;
    logic [CW-1:0]  idx_p1;

    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic [VW-1:0]  ram_wr_data;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    logic [VW-1:0]  ram_rd_data;

    pal_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign out_free = !r_out_vld || i_out_ready;
    assign cnt_w    = PW'(r_count);
    assign full     = (r_count == CW'(DEPTH));
    assign pos_m1   = i_cmd.position - PW'(1);
    assign ins_bad  = (i_cmd.position == '0) || (i_cmd.position > cnt_w + PW'(1));
    assign del_bad  = (i_cmd.position == '0) || (i_cmd.position > cnt_w);
    assign idx_p1   = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        emit        = 1'b0;
        o_pop       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        res.status         = ST_OK;
        res.found_position = '0;
        res.entry_value    = '0;
        res.last           = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            if (out_free) begin
                                emit    = 1'b1;
                                o_pop   = 1'b1;
                                n_count = '0;
                            end
                        end
                        OP_APPEND: begin
                            if (out_free) begin
                                emit  = 1'b1;
                                o_pop = 1'b1;
                                if (full) begin
                                    res.status = ST_FULL;
                                end else begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = AW'(r_count);
                                    ram_wr_data = i_cmd.value;
                                    n_count     = r_count + CW'(1);
                                end
                            end
                        end
                        OP_INSERT: begin
                            if (full || ins_bad) begin
                                if (out_free) begin
                                    emit       = 1'b1;
                                    o_pop      = 1'b1;
                                    res.status = full ? ST_FULL : ST_BADPOS;
                                end
                            end else begin
                                n_idx   = AW'(r_count);
                                n_state = S_INS_STEP;
                            end
                        end
                        OP_DELETE: begin
                            if (del_bad) begin
                                if (out_free) begin
                                    emit       = 1'b1;
                                    o_pop      = 1'b1;
                                    res.status = ST_BADPOS;
                                end
                            end else begin
                                n_idx   = AW'(pos_m1);
                                n_state = S_DEL_STEP;
                            end
                        end
                        OP_SEARCH, OP_DISPLAY: begin
                            if (r_count == '0) begin
                                if (out_free) begin
                                    emit       = 1'b1;
                                    o_pop      = 1'b1;
                                    res.status = (i_cmd.op == OP_SEARCH) ? ST_MISS : ST_OK;
                                end
                            end else begin
                                n_idx   = '0;
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                emit  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            // walk down from the tail, one entry moved per pass through the step and move states
            S_INS_STEP: begin
                if (r_idx == AW'(pos_m1)) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_idx;
                    ram_wr_data = i_cmd.value;
                    n_count     = r_count + CW'(1);
                    n_state     = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_idx - AW'(1);
                    n_state     = S_INS_MOVE;
                end
            end
            S_INS_MOVE: begin
                ram_wr_en = 1'b1;
                n_idx     = r_idx - AW'(1);
                n_state   = S_INS_STEP;
            end
            S_DEL_STEP: begin
                if (idx_p1 == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(idx_p1);
                    n_state     = S_DEL_MOVE;
                end
            end
            S_DEL_MOVE: begin
                ram_wr_en = 1'b1;
                n_idx     = AW'(idx_p1);
                n_state   = S_DEL_STEP;
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // shared read state for search and display scans
            S_SRCH_RD: begin
                ram_rd_en = 1'b1;
                n_state   = (i_cmd.op == OP_DISPLAY) ? S_DISP_OUT : S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (ram_rd_data == i_cmd.value) begin
                    res.found_position = PW'(idx_p1);
                    res.entry_value    = ram_rd_data;
                    if (out_free) begin
                        emit    = 1'b1;
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (idx_p1 == r_count) begin
                    res.status = ST_MISS;
                    if (out_free) begin
                        emit    = 1'b1;
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx   = AW'(idx_p1);
                    n_state = S_SRCH_RD;
                end
            end
            S_DISP_OUT: begin
                res.found_position = PW'(idx_p1);
                res.entry_value    = ram_rd_data;
                res.last           = (idx_p1 == r_count);
                if (out_free) begin
                    emit = 1'b1;
                    if (idx_p1 == r_count) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = AW'(idx_p1);
                        n_state = S_SRCH_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.entry_count = PW'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_wr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (CW'(ram_wr_addr) <= r_count))
        else $error("ram write beyond list tail");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result register overwritten before transfer");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count) && ($past(i_cmd.op) != OP_CLEAR))
        |-> ((r_count == $past(r_count) + CW'(1)) || (r_count + CW'(1) == $past(r_count))))
        else $error("entry count moved by more than one");

endmodule
